// ----- rtl/wspa_pkg.sv -----
package wspa_pkg;

    localparam int unsigned RING_DEPTH = 8;
    localparam int unsigned PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned SUM_W      = 16 + PTR_W;

    // numerator width: 8 bit pulses * 12 bit distance * 20 bit scale
    localparam int unsigned NUM_W = 40;

    localparam logic [19:0] SPEED_SCALE       = 20'd921600;
    localparam logic [16:0] CLAMP_BAND        = 17'd2560;
    localparam logic [15:0] LOCK_MIN_SPEED    = 16'd5120;
    localparam logic [31:0] LOCK_CHECK_GAP_MS = 32'd50;
    localparam logic [31:0] STANDSTILL_US     = 32'd1000000;
    localparam logic [31:0] HOLD_MS           = 32'd1000;
    localparam logic [31:0] LOCK_SHOW_MS      = 32'd2000;

    // register addresses (word index)
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_LOCK_EN = 3'd1;
    localparam logic [2:0] REG_DIST    = 3'd2;
    localparam logic [2:0] REG_MAX     = 3'd3;
    localparam logic [2:0] REG_REFRESH = 3'd4;

    // divider request and reply
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [31:0]       den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [NUM_W-1:0]  quo;
    } t_div_rsp;

endpackage

// ----- rtl/wspa_divider.sv -----
module wspa_divider
    import wspa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [NUM_W-1:0]          r_quo, n_quo;
    logic [32:0]               r_rem, n_rem;
    logic [31:0]               r_den;
    logic [$clog2(NUM_W+1)-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [33:0]               w_shift;
    logic [33:0]               w_diff;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {2'b00, r_den};
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (!w_diff[33]) begin
            n_rem = w_diff[32:0];
        end else begin
            n_rem = w_shift[32:0];
        end
        n_quo = {r_quo[NUM_W-2:0], !w_diff[33]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(NUM_W+1))'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- rtl/wheel_speed_pulse_averager.sv -----
// Wheel speed pulse averager. Each update transfer carries the current us and
// ms time, the pulse count since the last update and the time of the latest
// pulse; one result transfer (ring-averaged speed in 1/256 km/h and a wheel
// lock flag) follows each update. An update with pulses, or a lock test, runs
// one division through a shared 40-step radix-2 divider before its result is
// valid; other updates skip the divider. The input is not ready while an
// update is in work or its result waits, and the next update can be taken in
// the cycle after the result transfer. The user must write settings over the
// APB port only while the block is idle; the block itself does not enforce it.
module wheel_speed_pulse_averager
    import wspa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_now_us,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_new_pulses,
    input  logic [31:0] i_latest_pulse_us,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_average_speed,
    output logic        o_wheel_locked,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_UPD, S_REFRESH, S_OUT
    } t_state;

    // configuration
    logic [1:0]  r_mode;
    logic        r_lock_en;
    logic [11:0] r_dist;
    logic [15:0] r_max;
    logic [9:0]  r_refresh;

    // block state
    logic [31:0] r_handled_us, r_lock_check_ms, r_lock_seen_ms, r_refresh_ms;
    logic [31:0] r_held_ms;
    logic [15:0] r_interval, r_held, r_mean;
    logic [15:0] r_ring [RING_DEPTH];
    logic [PTR_W-1:0] r_ptr;
    logic [SUM_W-1:0] r_sum;

    // item registers
    t_state      r_state;
    logic [31:0] r_now_us, r_now_ms, r_latest_us;
    logic [7:0]  r_pulses;
    logic        r_is_lock;
    logic [31:0] r_prod;
    logic        r_valid, r_locked;
    t_div_req    w_req;
    t_div_rsp    w_rsp;

    wspa_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // apb
    logic       w_wr;
    logic [2:0] w_idx;
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    always_comb begin
        unique case (w_idx)
            REG_MODE:    prdata = {30'd0, r_mode};
            REG_LOCK_EN: prdata = {31'd0, r_lock_en};
            REG_DIST:    prdata = {20'd0, r_dist};
            REG_MAX:     prdata = {16'd0, r_max};
            REG_REFRESH: prdata = {22'd0, r_refresh};
            default:     prdata = '0;
        endcase
    end

    // decisions on the captured item
    logic        w_max_mode, w_clamp_mode;
    logic [31:0] w_end, w_elapsed, w_wait, w_gap;
    logic        w_lock_test, w_still;
    assign w_max_mode   = r_mode[1];
    assign w_clamp_mode = r_mode[0];
    assign w_end        = w_max_mode ? r_latest_us : r_now_us;
    assign w_elapsed    = w_end - r_handled_us;
    assign w_wait       = r_now_us - r_handled_us;
    assign w_gap        = r_now_ms - r_lock_check_ms;
    assign w_lock_test  = r_lock_en && (r_mean > LOCK_MIN_SPEED)
                          && (w_gap > LOCK_CHECK_GAP_MS);
    assign w_still      = w_wait > STANDSTILL_US;

    // speed from quotient, with saturation and zero cases
    logic [15:0] w_meas;
    always_comb begin
        if (r_dist == '0) begin
            w_meas = '0;
        end else if (w_elapsed == '0 || w_rsp.quo > 40'd65535) begin
            w_meas = 16'hFFFF;
        end else begin
            w_meas = w_rsp.quo[15:0];
        end
    end

    // interval speed after pulses
    logic [15:0] w_pick;
    logic [16:0] w_hi;
    logic signed [17:0] w_lo;
    logic [15:0] w_clamped;
    always_comb begin
        if (!w_max_mode) begin
            w_pick = w_meas;
        end else if (w_meas <= r_max && w_meas > r_interval) begin
            w_pick = w_meas;
        end else begin
            w_pick = r_interval;
        end
        w_hi = {1'b0, r_mean} + CLAMP_BAND;
        w_lo = $signed({2'b00, r_mean}) - $signed({1'b0, CLAMP_BAND});
        w_clamped = w_pick;
        if ({1'b0, w_pick} > w_hi) begin
            w_clamped = (w_hi > 17'd65535) ? 16'hFFFF : w_hi[15:0];
        end
        if ($signed({2'b00, w_pick}) < w_lo) begin
            w_clamped = w_lo[15:0];
        end
    end

    // lock comparison: 2 * wait > 7 * period (34/44 bit)
    logic [33:0] w_wait2;
    logic [43:0] w_per7;
    assign w_wait2 = {1'b0, w_wait, 1'b0};
    assign w_per7  = {w_rsp.quo, 3'b000} - {4'd0, w_rsp.quo};

    // refresh
    logic [31:0] w_since_ref;
    logic [15:0] w_push;
    logic [SUM_W-1:0] w_new_sum;
    assign w_since_ref = r_now_ms - r_refresh_ms;
    always_comb begin
        if (r_interval != '0) begin
            w_push = r_interval;
        end else if (r_held != '0 && (r_now_ms - r_held_ms) < HOLD_MS) begin
            w_push = r_held;
        end else begin
            w_push = '0;
        end
    end
    assign w_new_sum = r_sum - SUM_W'(r_ring[r_ptr]) + SUM_W'(w_push);

    // lock test divides distance * scale, speed path divides pulses * distance * scale
    assign w_req.start = (r_state == S_MUL);
    assign w_req.num   = r_is_lock ? NUM_W'(r_prod)
                         : NUM_W'(r_prod) * NUM_W'(SPEED_SCALE);
    assign w_req.den   = r_is_lock ? {16'd0, r_mean} : w_elapsed;

    assign o_ready = (r_state == S_IDLE) && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_mode <= '0; r_lock_en <= 1'b0; r_dist <= 12'd500;
            r_max <= 16'd38400; r_refresh <= 10'd100;
            r_handled_us <= '0; r_lock_check_ms <= '0; r_lock_seen_ms <= '0;
            r_refresh_ms <= '0; r_held_ms <= '0; r_interval <= '0;
            r_held <= '0; r_mean <= '0; r_ptr <= '0; r_sum <= '0;
            r_locked <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++) r_ring[i] <= '0;
        end else begin
            if (w_wr) begin
                unique case (w_idx)
                    REG_MODE:    r_mode <= pwdata[1:0];
                    REG_LOCK_EN: r_lock_en <= pwdata[0];
                    REG_DIST:    r_dist <= pwdata[11:0];
                    REG_MAX:     r_max <= pwdata[15:0];
                    REG_REFRESH: r_refresh <= pwdata[9:0];
                    default: ;
                endcase
            end
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_now_us <= i_now_us; r_now_ms <= i_now_ms;
                        r_pulses <= i_new_pulses; r_latest_us <= i_latest_pulse_us;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    // pick the path; division paths go through S_MUL
                    if (r_pulses != '0) begin
                        r_is_lock <= 1'b0;
                        r_prod <= 32'(r_pulses) * 32'(r_dist);
                        r_state <= S_MUL;
                    end else if (w_lock_test) begin
                        r_is_lock <= 1'b1;
                        r_prod <= 32'(r_dist) * 32'(SPEED_SCALE);
                        r_state <= S_MUL;
                    end else begin
                        if (w_still) begin
                            r_interval <= '0;
                            r_lock_check_ms <= r_now_ms;
                        end
                        r_state <= S_REFRESH;
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: begin
                    if (w_rsp.done) begin
                        if (r_is_lock) begin
                            if ({10'd0, w_wait2} > w_per7) begin
                                r_lock_seen_ms <= r_now_ms;
                                r_lock_check_ms <= r_now_ms;
                            end
                        end else begin
                            r_handled_us <= r_latest_us;
                            r_interval <= w_clamp_mode ? w_clamped : w_pick;
                            r_lock_check_ms <= r_now_ms;
                        end
                        r_state <= S_REFRESH;
                    end
                end
                S_REFRESH: begin
                    if (w_since_ref >= {22'd0, r_refresh}) begin
                        r_refresh_ms <= r_now_ms;
                        if (r_interval != '0) begin
                            r_held <= r_interval;
                            r_held_ms <= r_now_ms;
                        end
                        r_ring[r_ptr] <= w_push;
                        r_sum <= w_new_sum;
                        r_interval <= '0;
                        r_ptr <= (r_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                        r_mean <= 16'(w_new_sum / RING_DEPTH);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_locked <= (r_now_ms > LOCK_SHOW_MS)
                                && ((r_now_ms - r_lock_seen_ms) < LOCK_SHOW_MS);
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_average_speed = r_mean;
    assign o_wheel_locked  = r_locked;

    // result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(o_average_speed))
        else $error("result changed while stalled");

    // no new item while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !o_ready)
        else $error("ready while result pending");

    // divider only finishes during the division step
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside division step");

endmodule

// ----- test/wheel_speed_pulse_averager_checker.sv -----
`timescale 1ns / 100ps

// watches the update and result channels plus APB writes, keeps its own copy
// of the speed averaging state and compares every result transfer
module wheel_speed_pulse_averager_checker
    import wspa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_o_ready,
    input  logic [31:0] i_now_us,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_new_pulses,
    input  logic [31:0] i_latest_pulse_us,
    input  logic        i_o_valid,
    input  logic        i_ready,
    input  logic [15:0] i_average_speed,
    input  logic        i_wheel_locked,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] avg;
        logic        locked;
    } t_speed_result;

    t_speed_result speed_q[$];

    // configuration copy
    logic [1:0]  cfg_mode;
    logic        cfg_lock_en;
    logic [11:0] cfg_dist;
    logic [15:0] cfg_max;
    logic [9:0]  cfg_refresh;

    // averaging state copy
    logic [31:0] handled_us;
    logic [15:0] interval_spd;
    logic [31:0] lock_check_at;
    logic [31:0] lock_seen_at;
    logic [31:0] refresh_at;
    logic [15:0] held_spd;
    logic [31:0] held_at;
    logic [15:0] ring [RING_DEPTH];
    logic [PTR_W-1:0] ring_ptr;
    logic [SUM_W-1:0] ring_sum;
    logic [15:0] mean_spd;

    function automatic logic [15:0] measured_speed(logic [7:0] pulses, logic [31:0] elapsed);
        logic [63:0] num;
        logic [63:0] quo;
        num = 64'(pulses) * 64'(cfg_dist) * 64'(SPEED_SCALE);
        if (num == 0) return 16'd0;
        if (elapsed == 0) return 16'hFFFF;
        quo = num / 64'(elapsed);
        return (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
    endfunction

    function automatic logic [15:0] clamp_mean(logic [15:0] s);
        longint v;
        longint hi;
        longint lo;
        v  = longint'(s);
        hi = longint'(mean_spd) + longint'(CLAMP_BAND);
        lo = longint'(mean_spd) - longint'(CLAMP_BAND);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // one update through the averaging state
    task automatic apply_update(logic [31:0] now_us, logic [31:0] now_ms,
                                logic [7:0] pulses, logic [31:0] last_us);
        logic [15:0] s;
        logic [63:0] period;
        logic [63:0] wait_us;
        t_speed_result r;
        if (pulses != 0) begin
            s = measured_speed(pulses, (cfg_mode[1] ? last_us : now_us) - handled_us);
            handled_us = last_us;
            if (!cfg_mode[1]) begin
                interval_spd = s;
            end else if (s <= cfg_max && s > interval_spd) begin
                interval_spd = s;
            end
            if (cfg_mode[0]) interval_spd = clamp_mean(interval_spd);
            lock_check_at = now_ms;
        end else if (cfg_lock_en && mean_spd > LOCK_MIN_SPEED &&
                     now_ms - lock_check_at > LOCK_CHECK_GAP_MS) begin
            period  = (64'(cfg_dist) * 64'(SPEED_SCALE)) / 64'(mean_spd);
            wait_us = 64'(now_us - handled_us);
            if (2 * wait_us > 7 * period) begin
                lock_seen_at  = now_ms;
                lock_check_at = now_ms;
            end
        end else if (now_us - handled_us > STANDSTILL_US) begin
            interval_spd  = 0;
            lock_check_at = now_ms;
        end

        // ring push at each refresh interval
        if (now_ms - refresh_at >= 32'(cfg_refresh)) begin
            refresh_at = now_ms;
            if (interval_spd > 0) begin
                held_spd = interval_spd;
                held_at  = now_ms;
            end else if (held_spd > 0 && now_ms - held_at < HOLD_MS) begin
                interval_spd = held_spd;
            end
            ring_sum = ring_sum - SUM_W'(ring[ring_ptr]) + SUM_W'(interval_spd);
            ring[ring_ptr] = interval_spd;
            interval_spd = 0;
            ring_ptr = (ring_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : ring_ptr + 1'b1;
            mean_spd = 16'(ring_sum / RING_DEPTH);
        end

        r.avg    = mean_spd;
        r.locked = (now_ms > LOCK_SHOW_MS) && (now_ms - lock_seen_at < LOCK_SHOW_MS);
        speed_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_speed_result exp_r;
        if (!i_rst_n) begin
            cfg_mode = 0; cfg_lock_en = 0; cfg_dist = 500; cfg_max = 38400;
            cfg_refresh = 100;
            handled_us = 0; interval_spd = 0; lock_check_at = 0; lock_seen_at = 0;
            refresh_at = 0; held_spd = 0; held_at = 0;
            foreach (ring[k]) ring[k] = 0;
            ring_ptr = 0; ring_sum = 0; mean_spd = 0;
            speed_q.delete();
            o_errors = 0;
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_MODE:    cfg_mode    = i_pwdata[1:0];
                    REG_LOCK_EN: cfg_lock_en = i_pwdata[0];
                    REG_DIST:    cfg_dist    = i_pwdata[11:0];
                    REG_MAX:     cfg_max     = i_pwdata[15:0];
                    REG_REFRESH: cfg_refresh = i_pwdata[9:0];
                    default: ;
                endcase
            end
            // result transfer against the oldest expectation
            if (i_o_valid && i_ready) begin
                if (speed_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result avg %0d locked %0b", $realtime,
                             i_average_speed, i_wheel_locked);
                end else begin
                    exp_r = speed_q.pop_front();
                    if (i_average_speed !== exp_r.avg) begin
                        o_errors++;
                        $display("%0t: average_speed expected %0d actual %0d", $realtime,
                                 exp_r.avg, i_average_speed);
                    end
                    if (i_wheel_locked !== exp_r.locked) begin
                        o_errors++;
                        $display("%0t: wheel_locked expected %0b actual %0b", $realtime,
                                 exp_r.locked, i_wheel_locked);
                    end
                end
            end
            // update transfer
            if (i_valid && i_o_ready)
                apply_update(i_now_us, i_now_ms, i_new_pulses, i_latest_pulse_us);
        end
        o_pending = speed_q.size();
    end

endmodule

// ----- test/wheel_speed_pulse_averager_tb.sv -----
`timescale 1ns / 100ps

module wheel_speed_pulse_averager_tb
    import wspa_pkg::*;
();

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_now_us = '0;
    logic [31:0] i_now_ms = '0;
    logic [7:0]  i_new_pulses = '0;
    logic [31:0] i_latest_pulse_us = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_average_speed;
    logic        o_wheel_locked;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // running wheel time
    logic [31:0] wheel_us = 32'd5000;
    logic [31:0] wheel_ms = 32'd5;

    always #1 i_clk = ~i_clk;

    wheel_speed_pulse_averager DUT (.*);

    wheel_speed_pulse_averager_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_o_ready(o_ready),
        .i_now_us(i_now_us), .i_now_ms(i_now_ms), .i_new_pulses(i_new_pulses),
        .i_latest_pulse_us(i_latest_pulse_us), .i_o_valid(o_valid), .i_ready(i_ready),
        .i_average_speed(o_average_speed), .i_wheel_locked(o_wheel_locked),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    // result side stalls
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // one update transfer; valid stays high into the next call
    task automatic send_update(logic [31:0] us, logic [31:0] ms, logic [7:0] pulses,
                               logic [31:0] last_us);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_now_us = us;
        i_now_ms = ms;
        i_new_pulses = pulses;
        i_latest_pulse_us = last_us;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // setup and access phase of an APB write
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // drain all results before touching the registers
    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic set_config(logic [1:0] mode, logic lock_en, logic [11:0] dist_mm,
                              logic [15:0] max_spd, logic [9:0] refresh);
        wait_idle();
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_LOCK_EN, 32'(lock_en));
        write_reg(REG_DIST, 32'(dist_mm));
        write_reg(REG_MAX, 32'(max_spd));
        write_reg(REG_REFRESH, 32'(refresh));
    endtask

    // advance wheel time and send an update with pulses spread over the gap
    task automatic drive_step(int unsigned gap_ms, logic [7:0] pulses);
        logic [31:0] span;
        span = gap_ms * 1000 + $urandom_range(999);
        wheel_ms += gap_ms;
        wheel_us += span;
        send_update(wheel_us, wheel_ms, pulses, wheel_us - $urandom_range(span));
    endtask

    task automatic run_phase(int unsigned count);
        int unsigned pulse_pct;
        pulse_pct = 60;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(3))
                    0: pulse_pct = 0;
                    1: pulse_pct = 20;
                    2: pulse_pct = 60;
                    default: pulse_pct = 100;
                endcase
            end
            if ($urandom_range(99) < 8) begin
                // noise over the full field ranges
                send_update($urandom, $urandom, 8'($urandom), $urandom);
            end else if ($urandom_range(99) < 4) begin
                // long silence for standstill
                drive_step($urandom_range(1000, 1600), 8'd0);
            end else begin
                drive_step($urandom_range(0, 30),
                           ($urandom_range(99) < pulse_pct) ? 8'($urandom_range(1, 4)) : 8'd0);
            end
        end
    endtask

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset settings, extremes and corner cases
        send_update(32'd0, 32'd0, 8'd255, 32'd0);                 // zero elapsed
        send_update(32'd100, 32'd1, 8'd0, 32'd0);
        send_update(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
        send_update(32'd5, 32'd3, 8'd1, 32'd2);                   // time wrap
        send_update(32'd2_500_000, 32'd2500, 8'd0, 32'd0);        // standstill
        for (int k = 0; k < 6; k++) drive_step(20, 8'd3);
        set_config(2'd3, 1'b1, 12'd4095, 16'd0, 10'd0);
        send_update(32'h8000_0000, 32'h8000_0000, 8'd128, 32'h7FFF_0000);
        for (int k = 0; k < 4; k++) drive_step(5, 8'd2);
        set_config(2'd1, 1'b1, 12'd0, 16'd65535, 10'd1023);       // zero distance
        for (int k = 0; k < 4; k++) drive_step(300, 8'd1);
        drive_step(100, 8'd0);

        // random phases under three idling patterns
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: begin tx_idle_pct = 17; rx_idle_pct = 75; end
                1: begin tx_idle_pct = 75; rx_idle_pct = 17; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            case (ph)
                0: set_config(2'd0, 1'b1, 12'd500, 16'd38400, 10'd10);
                1: set_config(2'd1, 1'b1, 12'd1, 16'd20000, 10'd1);
                2: set_config(2'd2, 1'b1, 12'd2000, 16'd65535, 10'd50);
                3: set_config(2'd3, 1'b0, 12'd4095, 16'd0, 10'd1000);
                4: set_config(2'd2, 1'b1, 12'd800, 16'd30000, 10'd0);
                default: set_config(2'd3, 1'b1, 12'd300, 16'd38400, 10'd20);
            endcase
            run_phase(135);
        end

        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
